### hdl/xs_pkg.sv
// ----------------------------------------------------------------------------
// xs_pkg
// Shared constants and helpers for the xoshiro256** generator with SplitMix64
// seeding.
// ----------------------------------------------------------------------------
package xs_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = WORD_W / 2;
  localparam int WORD_COUNT = 4;
  localparam int IDX_W      = $clog2(WORD_COUNT);

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam int MIX_SHIFT_A = 30;
  localparam int MIX_SHIFT_B = 27;
  localparam int MIX_SHIFT_C = 31;
  localparam int XO_SHIFT    = 17;
  localparam int XO_ROT      = 45;
  localparam int SS_ROT      = 7;
  localparam int SS_MUL5_SH  = 2;
  localparam int SS_MUL9_SH  = 3;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  function automatic word_t rotl64(input word_t v, input int unsigned amt);
    return (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

### hdl/xs_mul64.sv
// ----------------------------------------------------------------------------
// xs_mul64
// Iterative 64x64 multiplier, low 64 bits of the product, built on one
// 32x32 multiplier used in turn for three partial products.
// ----------------------------------------------------------------------------
module xs_mul64
  import xs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t op_a,
  input  word_t op_b,
  output logic  done,
  output word_t prod
);

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [1:0]        step_r, step_nxt;
  word_t             a_r, a_nxt;
  word_t             b_r, b_nxt;
  word_t             acc_r, acc_nxt;
  logic [HALF_W-1:0] mx, my;
  word_t             pp;

  always_comb begin
    mx = a_r[HALF_W-1:0];
    my = b_r[HALF_W-1:0];
    unique case (step_r)
      STEP_LL: begin
        mx = a_r[HALF_W-1:0];
        my = b_r[HALF_W-1:0];
      end
      STEP_LH: begin
        mx = a_r[HALF_W-1:0];
        my = b_r[WORD_W-1:HALF_W];
      end
      STEP_HL: begin
        mx = a_r[WORD_W-1:HALF_W];
        my = b_r[HALF_W-1:0];
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
    pp = WORD_W'(mx) * WORD_W'(my);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      step_nxt = STEP_LL;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      unique case (step_r)
        STEP_LL: begin
          acc_nxt  = pp;
          step_nxt = STEP_LH;
        end
        STEP_LH: begin
          acc_nxt[WORD_W-1:HALF_W] = acc_r[WORD_W-1:HALF_W] + pp[HALF_W-1:0];
          step_nxt = STEP_HL;
        end
        STEP_HL: begin
          acc_nxt[WORD_W-1:HALF_W] = acc_r[WORD_W-1:HALF_W] + pp[HALF_W-1:0];
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_LL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### hdl/xoshiro256ss_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_generator
// xoshiro256** pseudo-random word generator with SplitMix64 seeding.
// ----------------------------------------------------------------------------
// A transaction with in_tuser = 1 draws one 64-bit word; one with in_tuser = 0
// reseeds from in_tdata and returns nothing. A draw forms its result in two
// 64-bit shift-add steps and writes it to the result register; it waits in
// its last step while the previous result is not yet taken. A reseed runs
// four SplitMix64 rounds on the shared iterative multiplier, which forms each
// 64-bit constant product from three 32x32 partial products. in_tready stays
// low while an item is in work, so the next transaction is taken only once
// the last one is through. Before any reseed every draw returns zero.
module xoshiro256ss_generator
  import xs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] seed
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] random_value
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MIX    = 3'd1;
  localparam logic [2:0] ST_WAIT_A = 3'd2;
  localparam logic [2:0] ST_WAIT_B = 3'd3;
  localparam logic [2:0] ST_DRAW_A = 3'd4;
  localparam logic [2:0] ST_DRAW_B = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  word_t            cnt_r, cnt_nxt;
  word_t            tmp_r, tmp_nxt;
  word_t            words_r [WORD_COUNT];
  word_t            words_nxt [WORD_COUNT];
  logic             out_valid_r, out_valid_nxt;
  word_t            out_data_r, out_data_nxt;

  logic  mul_start;
  word_t mul_a;
  word_t mul_b;
  logic  mul_done;
  word_t mul_prod;

  xs_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    word_t sum;
    word_t rot;
    word_t t2;
    word_t t3;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    tmp_nxt       = tmp_r;
    words_nxt     = words_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sum           = cnt_r + GOLDEN_STEP;
    rot           = rotl64(tmp_r, SS_ROT);
    t2            = words_r[2] ^ words_r[0];
    t3            = words_r[3] ^ words_r[1];
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == KIND_DRAW) begin
            state_nxt = ST_DRAW_A;
          end else begin
            cnt_nxt   = in_tdata;
            idx_nxt   = '0;
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        cnt_nxt   = sum;
        mul_start = 1'b1;
        mul_a     = sum ^ (sum >> MIX_SHIFT_A);
        mul_b     = MIX_MUL_A;
        state_nxt = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod ^ (mul_prod >> MIX_SHIFT_B);
          mul_b     = MIX_MUL_B;
          state_nxt = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        if (mul_done) begin
          words_nxt[idx_r] = mul_prod ^ (mul_prod >> MIX_SHIFT_C);
          if (idx_r == IDX_W'(WORD_COUNT - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MIX;
          end
        end
      end
      ST_DRAW_A: begin
        tmp_nxt   = words_r[1] + (words_r[1] << SS_MUL5_SH);
        state_nxt = ST_DRAW_B;
      end
      ST_DRAW_B: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = rot + (rot << SS_MUL9_SH);
          out_valid_nxt = 1'b1;
          words_nxt[0]  = words_r[0] ^ t3;
          words_nxt[1]  = words_r[1] ^ t2;
          words_nxt[2]  = t2 ^ (words_r[1] << XO_SHIFT);
          words_nxt[3]  = rotl64(t3, XO_ROT);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < WORD_COUNT; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      words_r     <= words_nxt;
    end
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/xs_checker.sv
// ----------------------------------------------------------------------------
// xs_checker
// Port-level checks for the xoshiro256** generator, bound to the top level.
// ----------------------------------------------------------------------------
module xs_checker
  import xs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready high right after an accepted transaction");

  a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == KIND_SEED) && !out_tvalid
    |=> !out_tvalid)
    else $error("reseed produced a result");

  a_reset_state: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind xoshiro256ss_generator xs_checker u_xs_checker (.*);
